// ----- hdl/hcb_pkg.sv -----
// ----------------------------------------------------------------------------
// hcb_pkg
// Shared widths, memory entry types and controller states of the Huffman
// code builder.
// ----------------------------------------------------------------------------
package hcb_pkg;

    localparam int SYM_W   = 8;
    localparam int CNT_W   = 32;
    localparam int NF_W    = CNT_W + 8;
    localparam int ID_W    = 9;
    localparam int CODE_W  = 64;
    localparam int LEN_W   = 7;
    localparam int DEP_W   = 8;
    localparam int TOT_W   = 48;
    localparam int ACC_W   = TOT_W + 1;
    localparam int PROD_W  = CNT_W + DEP_W;
    localparam int IDX_W   = 10;
    localparam int SYM_N   = 256;
    localparam int NODE_N  = 512;
    localparam int WL_N    = 512;

    localparam logic [1:0] ACT_COUNT  = 2'd0;
    localparam logic [1:0] ACT_BUILD  = 2'd1;
    localparam logic [1:0] ACT_LOOKUP = 2'd2;
    localparam logic [1:0] ACT_CLEAR  = 2'd3;

    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(CODE_W);

    typedef struct packed {
        logic            alive;
        logic [ID_W-1:0] id;
        logic [NF_W-1:0] freq;
    } t_wl_ent;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [DEP_W-1:0]  depth;
    } t_node_info;

    typedef struct packed {
        logic [LEN_W-1:0]  len;
        logic [CODE_W-1:0] code;
    } t_code_ent;

    typedef struct packed {
        logic [ID_W-1:0] ch0;
        logic [ID_W-1:0] ch1;
    } t_children;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CNT,
        S_LOOK,
        S_LOAD,
        S_SCAN,
        S_KILL_A,
        S_KILL_B,
        S_APPEND,
        S_ROOT,
        S_TRV_RD,
        S_TRV_W0,
        S_TRV_W1,
        S_FIN,
        S_DONE
    } t_state;

endpackage

// ----- hdl/hcb_ram.sv -----
// ----------------------------------------------------------------------------
// hcb_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module hcb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/huffman_code_builder_core.sv -----
// ----------------------------------------------------------------------------
// huffman_code_builder_core
// Counts symbol frequencies, builds a static Huffman code and answers code
// lookups.
// ----------------------------------------------------------------------------
// One item at a time; busy is high while an item is in work. A count reads
// the frequency, then writes it back; a lookup reads the code table, then
// gives its result strobe. A build walks memories: it loads the present
// symbols, then for each of the n-1 merges makes one pass over the whole
// work list (one entry per cycle on the single read port), assigns codes
// per internal node, and fills the code table for n distinct symbols.
// Results come as a one-cycle o_valid strobe; the receiver cannot stall
// them.
module huffman_code_builder_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  i_action,
    input  logic [hcb_pkg::SYM_W-1:0]   i_symbol,
    output logic                        o_valid,
    output logic [7:0]                  o_distinct_count,
    output logic [hcb_pkg::TOT_W-1:0]   o_total_bits,
    output logic [hcb_pkg::CODE_W-1:0]  o_code_bits,
    output logic [hcb_pkg::LEN_W-1:0]   o_code_length,
    output logic                        o_present
);

    hcb_pkg::t_state r_state, n_state;

    logic [7:0]                  r_sym, n_sym;
    logic                        r_symok, n_symok;
    logic [hcb_pkg::IDX_W-1:0]   r_idx, n_idx;
    logic                        r_pv, n_pv;
    logic [8:0]                  r_ppos, n_ppos;
    logic [8:0]                  r_tail, n_tail;
    logic [7:0]                  r_distinct, n_distinct;
    logic [7:0]                  r_internal, n_internal;
    logic [7:0]                  r_k, n_k;
    logic                        r_has1, n_has1, r_has2, n_has2;
    logic [hcb_pkg::NF_W-1:0]    r_f1, n_f1, r_f2, n_f2;
    logic [8:0]                  r_p1, n_p1, r_p2, n_p2;
    logic [hcb_pkg::ID_W-1:0]    r_id1, n_id1, r_id2, n_id2;
    logic [hcb_pkg::ID_W-1:0]    r_ch1, n_ch1;
    logic [hcb_pkg::CODE_W-1:0]  r_pcode, n_pcode;
    logic [hcb_pkg::DEP_W-1:0]   r_pdep, n_pdep;
    logic [hcb_pkg::PROD_W-1:0]  r_prod, n_prod;
    logic                        r_mv, n_mv;
    logic [hcb_pkg::ACC_W-1:0]   r_acc, n_acc;
    logic [hcb_pkg::SYM_N-1:0]   r_sf_vld, r_ct_vld;
    logic                        r_sf_rv, r_ct_rv;

    logic                        r_ovalid, n_ovalid;
    logic [7:0]                  r_odist, n_odist;
    logic [hcb_pkg::TOT_W-1:0]   r_ototal, n_ototal;
    logic [hcb_pkg::CODE_W-1:0]  r_ocode, n_ocode;
    logic [hcb_pkg::LEN_W-1:0]   r_olen, n_olen;
    logic                        r_opres, n_opres;

    // memory ports
    logic                        sf_we;
    logic [7:0]                  sf_waddr, sf_raddr;
    logic [hcb_pkg::CNT_W-1:0]   sf_wdata, sf_rdata, sf_eff;
    logic                        wl_we;
    logic [8:0]                  wl_waddr, wl_raddr;
    hcb_pkg::t_wl_ent            wl_wdata, wl_rdata;
    logic                        ch_we;
    logic [7:0]                  ch_waddr, ch_raddr;
    hcb_pkg::t_children          ch_wdata, ch_rdata;
    logic                        ni_we;
    logic [8:0]                  ni_waddr, ni_raddr;
    hcb_pkg::t_node_info         ni_wdata, ni_rdata;
    logic                        ct_we;
    logic [7:0]                  ct_waddr, ct_raddr;
    hcb_pkg::t_code_ent          ct_wdata, ct_rdata;

    logic                        clr_all, ct_clr, accept;
    logic [hcb_pkg::DEP_W-1:0]   fin_dep;
    logic [hcb_pkg::CODE_W-1:0]  fin_code;

    hcb_ram #(.WIDTH(hcb_pkg::CNT_W), .DEPTH(hcb_pkg::SYM_N)) u_sym_freq (
        .i_clk(i_clk), .i_we(sf_we), .i_waddr(sf_waddr), .i_wdata(sf_wdata),
        .i_raddr(sf_raddr), .o_rdata(sf_rdata)
    );

    hcb_ram #(.WIDTH($bits(hcb_pkg::t_wl_ent)), .DEPTH(hcb_pkg::WL_N)) u_work_list (
        .i_clk(i_clk), .i_we(wl_we), .i_waddr(wl_waddr), .i_wdata(wl_wdata),
        .i_raddr(wl_raddr), .o_rdata(wl_rdata)
    );

    hcb_ram #(.WIDTH($bits(hcb_pkg::t_children)), .DEPTH(hcb_pkg::SYM_N)) u_children (
        .i_clk(i_clk), .i_we(ch_we), .i_waddr(ch_waddr), .i_wdata(ch_wdata),
        .i_raddr(ch_raddr), .o_rdata(ch_rdata)
    );

    hcb_ram #(.WIDTH($bits(hcb_pkg::t_node_info)), .DEPTH(hcb_pkg::NODE_N)) u_node_info (
        .i_clk(i_clk), .i_we(ni_we), .i_waddr(ni_waddr), .i_wdata(ni_wdata),
        .i_raddr(ni_raddr), .o_rdata(ni_rdata)
    );

    hcb_ram #(.WIDTH($bits(hcb_pkg::t_code_ent)), .DEPTH(hcb_pkg::SYM_N)) u_code_table (
        .i_clk(i_clk), .i_we(ct_we), .i_waddr(ct_waddr), .i_wdata(ct_wdata),
        .i_raddr(ct_raddr), .o_rdata(ct_rdata)
    );

    assign busy   = (r_state != hcb_pkg::S_IDLE);
    assign accept = start && !busy;
    assign sf_eff = r_sf_rv ? sf_rdata : '0;

    // lone symbol gets code 0 of length 1
    assign fin_dep  = (r_distinct == 8'd1) ? hcb_pkg::DEP_W'(1) : ni_rdata.depth;
    assign fin_code = (r_distinct == 8'd1) ? '0 : ni_rdata.code;

    always_comb begin
        n_state    = r_state;
        n_sym      = r_sym;
        n_symok    = r_symok;
        n_idx      = r_idx;
        n_pv       = 1'b0;
        n_ppos     = r_ppos;
        n_tail     = r_tail;
        n_distinct = r_distinct;
        n_internal = r_internal;
        n_k        = r_k;
        n_has1     = r_has1;
        n_has2     = r_has2;
        n_f1       = r_f1;
        n_f2       = r_f2;
        n_p1       = r_p1;
        n_p2       = r_p2;
        n_id1      = r_id1;
        n_id2      = r_id2;
        n_ch1      = r_ch1;
        n_pcode    = r_pcode;
        n_pdep     = r_pdep;
        n_prod     = r_prod;
        n_mv       = 1'b0;
        n_acc      = r_acc;
        n_ovalid   = 1'b0;
        n_odist    = r_odist;
        n_ototal   = r_ototal;
        n_ocode    = r_ocode;
        n_olen     = r_olen;
        n_opres    = r_opres;

        clr_all  = 1'b0;
        ct_clr   = 1'b0;
        sf_we    = 1'b0;
        sf_waddr = r_sym;
        sf_wdata = sf_eff + hcb_pkg::CNT_W'(1);
        sf_raddr = i_symbol;
        wl_we    = 1'b0;
        wl_waddr = r_tail;
        wl_wdata = '0;
        wl_raddr = r_idx[8:0];
        ch_we    = 1'b0;
        ch_waddr = r_internal;
        ch_wdata = '{ch0: r_id1, ch1: r_id2};
        ch_raddr = r_k;
        ni_we    = 1'b0;
        ni_waddr = {1'b1, r_internal - 8'd1};
        ni_wdata = '0;
        ni_raddr = {1'b1, r_k};
        ct_we    = 1'b0;
        ct_waddr = r_ppos[7:0];
        ct_wdata = '{len: (fin_dep > hcb_pkg::DEP_W'(hcb_pkg::CODE_W)) ?
                          hcb_pkg::MAX_LEN : hcb_pkg::LEN_W'(fin_dep),
                     code: fin_code};
        ct_raddr = i_symbol;

        case (r_state)
            hcb_pkg::S_IDLE: begin
                if (accept) begin
                    n_sym   = i_symbol;
                    n_symok = (i_symbol != '0);
                    case (i_action)
                        hcb_pkg::ACT_COUNT: begin
                            if (i_symbol != '0) begin
                                n_state = hcb_pkg::S_CNT;
                            end
                        end
                        hcb_pkg::ACT_BUILD: begin
                            ct_clr     = 1'b1;
                            n_tail     = '0;
                            n_distinct = '0;
                            n_internal = '0;
                            n_acc      = '0;
                            n_idx      = hcb_pkg::IDX_W'(1);
                            n_state    = hcb_pkg::S_LOAD;
                        end
                        hcb_pkg::ACT_LOOKUP: begin
                            n_state = hcb_pkg::S_LOOK;
                        end
                        default: begin
                            clr_all = 1'b1;
                        end
                    endcase
                end
            end

            hcb_pkg::S_CNT: begin
                if (sf_eff != '1) begin
                    sf_we = 1'b1;
                end
                n_state = hcb_pkg::S_IDLE;
            end

            hcb_pkg::S_LOOK: begin
                n_ovalid = 1'b1;
                n_odist  = '0;
                n_ototal = '0;
                if (r_symok && r_ct_rv && ct_rdata.len != '0) begin
                    n_ocode = ct_rdata.code;
                    n_olen  = ct_rdata.len;
                    n_opres = 1'b1;
                end else begin
                    n_ocode = '0;
                    n_olen  = '0;
                    n_opres = 1'b0;
                end
                n_state = hcb_pkg::S_IDLE;
            end

            hcb_pkg::S_LOAD: begin
                // read pipeline over symbols 1..255, append present ones
                sf_raddr = r_idx[7:0];
                if (r_idx < hcb_pkg::IDX_W'(hcb_pkg::SYM_N)) begin
                    n_pv   = 1'b1;
                    n_ppos = r_idx[8:0];
                    n_idx  = r_idx + hcb_pkg::IDX_W'(1);
                end
                if (r_pv && sf_eff != '0) begin
                    wl_we      = 1'b1;
                    wl_wdata   = '{alive: 1'b1, id: r_ppos,
                                   freq: hcb_pkg::NF_W'(sf_eff)};
                    n_tail     = r_tail + 9'd1;
                    n_distinct = r_distinct + 8'd1;
                end
                if (r_idx >= hcb_pkg::IDX_W'(hcb_pkg::SYM_N) && !r_pv) begin
                    n_idx  = '0;
                    n_has1 = 1'b0;
                    n_has2 = 1'b0;
                    if (r_distinct > 8'd1) begin
                        n_state = hcb_pkg::S_SCAN;
                    end else begin
                        n_idx   = hcb_pkg::IDX_W'(1);
                        n_state = hcb_pkg::S_FIN;
                    end
                end
            end

            hcb_pkg::S_SCAN: begin
                // earliest minimum and earliest minimum of the rest
                if (r_idx < {1'b0, r_tail}) begin
                    n_pv   = 1'b1;
                    n_ppos = r_idx[8:0];
                    n_idx  = r_idx + hcb_pkg::IDX_W'(1);
                end
                if (r_pv && wl_rdata.alive) begin
                    if (!r_has1 || wl_rdata.freq < r_f1) begin
                        n_has2 = r_has1;
                        n_f2   = r_f1;
                        n_p2   = r_p1;
                        n_id2  = r_id1;
                        n_has1 = 1'b1;
                        n_f1   = wl_rdata.freq;
                        n_p1   = r_ppos;
                        n_id1  = wl_rdata.id;
                    end else if (!r_has2 || wl_rdata.freq < r_f2) begin
                        n_has2 = 1'b1;
                        n_f2   = wl_rdata.freq;
                        n_p2   = r_ppos;
                        n_id2  = wl_rdata.id;
                    end
                end
                if (r_idx >= {1'b0, r_tail} && !r_pv) begin
                    n_state = hcb_pkg::S_KILL_A;
                end
            end

            hcb_pkg::S_KILL_A: begin
                wl_we    = 1'b1;
                wl_waddr = r_p1;
                n_state  = hcb_pkg::S_KILL_B;
            end

            hcb_pkg::S_KILL_B: begin
                wl_we    = 1'b1;
                wl_waddr = r_p2;
                ch_we    = 1'b1;
                n_state  = hcb_pkg::S_APPEND;
            end

            hcb_pkg::S_APPEND: begin
                wl_we      = 1'b1;
                wl_wdata   = '{alive: 1'b1, id: {1'b1, r_internal}, freq: r_f1 + r_f2};
                n_tail     = r_tail + 9'd1;
                n_internal = r_internal + 8'd1;
                n_idx      = '0;
                n_has1     = 1'b0;
                n_has2     = 1'b0;
                if (r_internal + 8'd1 == r_distinct - 8'd1) begin
                    n_state = hcb_pkg::S_ROOT;
                end else begin
                    n_state = hcb_pkg::S_SCAN;
                end
            end

            hcb_pkg::S_ROOT: begin
                ni_we   = 1'b1;
                n_k     = r_internal - 8'd1;
                n_state = hcb_pkg::S_TRV_RD;
            end

            hcb_pkg::S_TRV_RD: begin
                n_state = hcb_pkg::S_TRV_W0;
            end

            hcb_pkg::S_TRV_W0: begin
                ni_we    = 1'b1;
                ni_waddr = ch_rdata.ch0;
                ni_wdata = '{code: {ni_rdata.code[hcb_pkg::CODE_W-2:0], 1'b0},
                             depth: ni_rdata.depth + hcb_pkg::DEP_W'(1)};
                n_ch1    = ch_rdata.ch1;
                n_pcode  = ni_rdata.code;
                n_pdep   = ni_rdata.depth;
                n_state  = hcb_pkg::S_TRV_W1;
            end

            hcb_pkg::S_TRV_W1: begin
                ni_we    = 1'b1;
                ni_waddr = r_ch1;
                ni_wdata = '{code: {r_pcode[hcb_pkg::CODE_W-2:0], 1'b1},
                             depth: r_pdep + hcb_pkg::DEP_W'(1)};
                if (r_k == '0) begin
                    n_idx   = hcb_pkg::IDX_W'(1);
                    n_state = hcb_pkg::S_FIN;
                end else begin
                    n_k     = r_k - 8'd1;
                    n_state = hcb_pkg::S_TRV_RD;
                end
            end

            hcb_pkg::S_FIN: begin
                sf_raddr = r_idx[7:0];
                ni_raddr = {1'b0, r_idx[7:0]};
                if (r_idx < hcb_pkg::IDX_W'(hcb_pkg::SYM_N)) begin
                    n_pv   = 1'b1;
                    n_ppos = r_idx[8:0];
                    n_idx  = r_idx + hcb_pkg::IDX_W'(1);
                end
                if (r_pv && sf_eff != '0) begin
                    ct_we  = 1'b1;
                    n_prod = hcb_pkg::PROD_W'(sf_eff) * hcb_pkg::PROD_W'(fin_dep);
                    n_mv   = 1'b1;
                end
                if (r_mv) begin
                    n_acc = r_acc + hcb_pkg::ACC_W'(r_prod);
                end
                if (r_idx >= hcb_pkg::IDX_W'(hcb_pkg::SYM_N) && !r_pv && !r_mv) begin
                    n_state = hcb_pkg::S_DONE;
                end
            end

            hcb_pkg::S_DONE: begin
                n_ovalid = 1'b1;
                n_odist  = r_distinct;
                n_ototal = r_acc[hcb_pkg::ACC_W-1] ? '1 : r_acc[hcb_pkg::TOT_W-1:0];
                n_ocode  = '0;
                n_olen   = '0;
                n_opres  = 1'b0;
                n_state  = hcb_pkg::S_IDLE;
            end

            default: begin
                n_state = hcb_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= hcb_pkg::S_IDLE;
            r_pv     <= 1'b0;
            r_mv     <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_pv     <= n_pv;
            r_mv     <= n_mv;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sym      <= n_sym;
        r_symok    <= n_symok;
        r_idx      <= n_idx;
        r_ppos     <= n_ppos;
        r_tail     <= n_tail;
        r_distinct <= n_distinct;
        r_internal <= n_internal;
        r_k        <= n_k;
        r_has1     <= n_has1;
        r_has2     <= n_has2;
        r_f1       <= n_f1;
        r_f2       <= n_f2;
        r_p1       <= n_p1;
        r_p2       <= n_p2;
        r_id1      <= n_id1;
        r_id2      <= n_id2;
        r_ch1      <= n_ch1;
        r_pcode    <= n_pcode;
        r_pdep     <= n_pdep;
        r_prod     <= n_prod;
        r_acc      <= n_acc;
        r_odist    <= n_odist;
        r_ototal   <= n_ototal;
        r_ocode    <= n_ocode;
        r_olen     <= n_olen;
        r_opres    <= n_opres;
        r_sf_rv    <= r_sf_vld[sf_raddr];
        r_ct_rv    <= r_ct_vld[ct_raddr];
    end

    // entry valid bits: an entry never written reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || clr_all) begin
            r_sf_vld <= '0;
        end else if (sf_we) begin
            r_sf_vld[sf_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || clr_all || ct_clr) begin
            r_ct_vld <= '0;
        end else if (ct_we) begin
            r_ct_vld[ct_waddr] <= 1'b1;
        end
    end

    assign o_valid          = r_ovalid;
    assign o_distinct_count = r_odist;
    assign o_total_bits     = r_ototal;
    assign o_code_bits      = r_ocode;
    assign o_code_length    = r_olen;
    assign o_present        = r_opres;

endmodule

// ----- dv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Huffman code builder core: directed and random
// count/build/lookup/clear items, with results predicted by an in-bench model.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam longint TOT_MAX   = (64'd1 << hcb_pkg::TOT_W) - 1;
    localparam int     CYCLE_CAP = 3000000;

    typedef struct {
        logic [1:0]                action;
        logic [hcb_pkg::SYM_W-1:0] symbol;
        bit                        drain;
    } t_item;

    typedef struct {
        logic [7:0]                 distinct;
        logic [hcb_pkg::TOT_W-1:0]  total;
        logic [hcb_pkg::CODE_W-1:0] code;
        logic [hcb_pkg::LEN_W-1:0]  len;
        logic                       present;
    } t_answer;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        start = 1'b0;
    logic                        busy;
    logic [1:0]                  i_action = hcb_pkg::ACT_COUNT;
    logic [hcb_pkg::SYM_W-1:0]   i_symbol = '0;
    logic                        o_valid;
    logic [7:0]                  o_distinct_count;
    logic [hcb_pkg::TOT_W-1:0]   o_total_bits;
    logic [hcb_pkg::CODE_W-1:0]  o_code_bits;
    logic [hcb_pkg::LEN_W-1:0]   o_code_length;
    logic                        o_present;

    t_item   pending_items[$];
    t_answer expected_answers[$];
    int      errors = 0;
    int      cycles = 0;
    int      gap_left = 0;
    int      burst_left = 0;

    // predictor state
    logic [hcb_pkg::CNT_W-1:0]  sym_freq[hcb_pkg::SYM_N];
    logic [hcb_pkg::CODE_W-1:0] tbl_code[hcb_pkg::SYM_N];
    logic [hcb_pkg::LEN_W-1:0]  tbl_len[hcb_pkg::SYM_N];

    huffman_code_builder_core uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_action         (i_action),
        .i_symbol         (i_symbol),
        .o_valid          (o_valid),
        .o_distinct_count (o_distinct_count),
        .o_total_bits     (o_total_bits),
        .o_code_bits      (o_code_bits),
        .o_code_length    (o_code_length),
        .o_present        (o_present)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void clear_model();
        for (int s = 0; s < hcb_pkg::SYM_N; s++) begin
            sym_freq[s] = '0;
            tbl_code[s] = '0;
            tbl_len[s]  = '0;
        end
    endfunction

    // removes the earliest minimum from the node list
    function automatic int pop_min(ref int nodes[$],
                                   ref logic [hcb_pkg::NF_W-1:0] nf[hcb_pkg::NODE_N]);
        int best;
        int id;
        best = 0;
        for (int i = 1; i < nodes.size(); i++)
            if (nf[nodes[i]] < nf[nodes[best]]) best = i;
        id = nodes[best];
        nodes.delete(best);
        return id;
    endfunction

    function automatic t_answer build_codes();
        t_answer                    ans;
        int                         nodes[$];
        logic [hcb_pkg::NF_W-1:0]   nf[hcb_pkg::NODE_N];
        int                         kid0[hcb_pkg::SYM_N];
        int                         kid1[hcb_pkg::SYM_N];
        logic [hcb_pkg::CODE_W-1:0] ncode[hcb_pkg::NODE_N];
        int                         ndepth[hcb_pkg::NODE_N];
        int                         merges;
        int                         a;
        int                         b;
        int                         p;
        logic [63:0]                total;
        ans = '{default: '0};
        total = '0;
        merges = 0;
        for (int s = 0; s < hcb_pkg::SYM_N; s++) begin
            tbl_code[s] = '0;
            tbl_len[s]  = '0;
        end
        for (int s = 1; s < hcb_pkg::SYM_N; s++)
            if (sym_freq[s] != 0) begin
                nf[s] = hcb_pkg::NF_W'(sym_freq[s]);
                nodes = {nodes, s};
            end
        ans.distinct = 8'(nodes.size());
        if (nodes.size() == 1) begin
            tbl_len[nodes[0]] = hcb_pkg::LEN_W'(1);
            total = 64'(sym_freq[nodes[0]]);
        end else if (nodes.size() > 1) begin
            while (nodes.size() > 1) begin
                a = pop_min(nodes, nf);
                b = pop_min(nodes, nf);
                kid0[merges] = a;
                kid1[merges] = b;
                nf[256 + merges] = nf[a] + nf[b];
                nodes = {nodes, 256 + merges};
                merges++;
            end
            ncode[256 + merges - 1]  = '0;
            ndepth[256 + merges - 1] = 0;
            for (int k = merges - 1; k >= 0; k--) begin
                p = 256 + k;
                ncode[kid0[k]]  = ncode[p] << 1;
                ndepth[kid0[k]] = ndepth[p] + 1;
                ncode[kid1[k]]  = (ncode[p] << 1) | 64'd1;
                ndepth[kid1[k]] = ndepth[p] + 1;
            end
            for (int s = 1; s < hcb_pkg::SYM_N; s++)
                if (sym_freq[s] != 0) begin
                    tbl_code[s] = ncode[s];
                    tbl_len[s]  = (ndepth[s] > hcb_pkg::CODE_W) ?
                                  hcb_pkg::LEN_W'(hcb_pkg::CODE_W) :
                                  hcb_pkg::LEN_W'(ndepth[s]);
                    total += 64'(sym_freq[s]) * 64'(ndepth[s]);
                end
        end
        ans.total = (total > TOT_MAX) ? hcb_pkg::TOT_W'(TOT_MAX) : hcb_pkg::TOT_W'(total);
        return ans;
    endfunction

    task automatic apply_item(input logic [1:0] act, input logic [hcb_pkg::SYM_W-1:0] sym);
        t_answer ans;
        ans = '{default: '0};
        case (act)
            hcb_pkg::ACT_COUNT: begin
                if (sym != 0 && sym_freq[sym] != '1) sym_freq[sym]++;
            end
            hcb_pkg::ACT_BUILD: begin
                expected_answers = {expected_answers, build_codes()};
            end
            hcb_pkg::ACT_LOOKUP: begin
                if (sym != 0 && tbl_len[sym] != 0) begin
                    ans.code    = tbl_code[sym];
                    ans.len     = tbl_len[sym];
                    ans.present = 1'b1;
                end
                expected_answers = {expected_answers, ans};
            end
            default: clear_model();
        endcase
    endtask

    // driver
    always @(posedge i_clk) begin
        t_item nxt;
        logic  go;
        go = start;
        if (!i_rst_n) begin
            go = 1'b0;
        end else begin
            if (start && !busy) apply_item(i_action, i_symbol);
            if (!start || !busy) begin
                go = 1'b0;
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_items.size() != 0 &&
                             !(pending_items[0].drain && expected_answers.size() != 0)) begin
                    nxt = pending_items.pop_front();
                    i_action <= nxt.action;
                    i_symbol <= nxt.symbol;
                    go = 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 30);
                        gap_left   = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 7);
                    end
                end
            end
        end
        start <= go;
    end

    // monitor
    always @(posedge i_clk) begin
        t_answer exp_ans;
        if (i_rst_n && o_valid) begin
            if (expected_answers.size() == 0) begin
                $display("%0t: unexpected result, distinct %0d total %0d code %h len %0d",
                         $realtime, o_distinct_count, o_total_bits, o_code_bits,
                         o_code_length);
                errors++;
            end else begin
                exp_ans = expected_answers.pop_front();
                if (o_distinct_count !== exp_ans.distinct) begin
                    $display("%0t: distinct_count expected %0d actual %0d",
                             $realtime, exp_ans.distinct, o_distinct_count);
                    errors++;
                end
                if (o_total_bits !== exp_ans.total) begin
                    $display("%0t: total_bits expected %0d actual %0d",
                             $realtime, exp_ans.total, o_total_bits);
                    errors++;
                end
                if (o_code_bits !== exp_ans.code) begin
                    $display("%0t: code_bits expected %h actual %h",
                             $realtime, exp_ans.code, o_code_bits);
                    errors++;
                end
                if (o_code_length !== exp_ans.len) begin
                    $display("%0t: code_length expected %0d actual %0d",
                             $realtime, exp_ans.len, o_code_length);
                    errors++;
                end
                if (o_present !== exp_ans.present) begin
                    $display("%0t: present expected %0d actual %0d",
                             $realtime, exp_ans.present, o_present);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_CAP) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic add_item(input logic [1:0] act, input int sym, input bit drain = 0);
        t_item it;
        it.action = act;
        it.symbol = hcb_pkg::SYM_W'(sym);
        it.drain  = drain;
        pending_items = {pending_items, it};
    endtask

    // optional clear, skewed counts over a random alphabet, build, lookups, maybe one more count
    task automatic add_sequence();
        int alpha;
        int base;
        int cnt;
        int looks;
        int sym;
        alpha = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 48) : $urandom_range(1, 16);
        base  = $urandom_range(1, 255 - alpha + 1);
        cnt   = $urandom_range(alpha, alpha * 3);
        if ($urandom_range(0, 3) != 0) add_item(hcb_pkg::ACT_CLEAR, $urandom_range(0, 255));
        for (int i = 0; i < cnt; i++) begin
            // low offsets more likely so frequencies differ
            sym = base + ($urandom_range(0, alpha - 1) & $urandom_range(0, alpha - 1));
            if ($urandom_range(0, 19) == 0) sym = $urandom_range(0, 255) & ~$urandom_range(0, 255);
            add_item(hcb_pkg::ACT_COUNT, sym);
        end
        add_item(hcb_pkg::ACT_BUILD, $urandom_range(0, 255));
        looks = $urandom_range(1, 8);
        for (int i = 0; i < looks; i++)
            add_item(hcb_pkg::ACT_LOOKUP,
                     ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                 : base + $urandom_range(0, alpha - 1));
        if ($urandom_range(0, 5) == 0) add_item(hcb_pkg::ACT_COUNT, base);
    endtask

    initial begin
        clear_model();
        // directed part
        add_item(hcb_pkg::ACT_BUILD, 0);
        add_item(hcb_pkg::ACT_LOOKUP, 5);
        add_item(hcb_pkg::ACT_COUNT, 1);
        add_item(hcb_pkg::ACT_COUNT, 2);
        add_item(hcb_pkg::ACT_COUNT, 2);
        add_item(hcb_pkg::ACT_COUNT, 255);
        add_item(hcb_pkg::ACT_COUNT, 0);
        add_item(hcb_pkg::ACT_BUILD, 255);
        add_item(hcb_pkg::ACT_LOOKUP, 1);
        add_item(hcb_pkg::ACT_LOOKUP, 2);
        add_item(hcb_pkg::ACT_LOOKUP, 255);
        add_item(hcb_pkg::ACT_LOOKUP, 0);
        add_item(hcb_pkg::ACT_LOOKUP, 128);
        add_item(hcb_pkg::ACT_COUNT, 170);
        add_item(hcb_pkg::ACT_LOOKUP, 170);
        add_item(hcb_pkg::ACT_CLEAR, 85, 1);
        add_item(hcb_pkg::ACT_LOOKUP, 1);
        add_item(hcb_pkg::ACT_COUNT, 7);
        add_item(hcb_pkg::ACT_COUNT, 7);
        add_item(hcb_pkg::ACT_BUILD, 0);
        add_item(hcb_pkg::ACT_LOOKUP, 7);
        add_item(hcb_pkg::ACT_CLEAR, 0);
        // full alphabet, one count each
        for (int s = 1; s < hcb_pkg::SYM_N; s++) add_item(hcb_pkg::ACT_COUNT, s);
        add_item(hcb_pkg::ACT_BUILD, 0);
        add_item(hcb_pkg::ACT_LOOKUP, 1);
        add_item(hcb_pkg::ACT_LOOKUP, 254);
        // random part
        while (pending_items.size() < 900) add_sequence();

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (pending_items.size() == 0);
        @(posedge i_clk);
        while (start || expected_answers.size() != 0) @(posedge i_clk);
        repeat (600) @(posedge i_clk);
        if (errors == 0 && expected_answers.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
